FILE: hdl/pdmq_pkg.sv
// ----------------------------------------------------------------------------
// pdmq_pkg
// Shared codes, defaults and the control word that travels from the
// classifier to the packet store.
// ----------------------------------------------------------------------------
package pdmq_pkg;

    localparam int NUM_QUEUES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PACKET_WIDTH_DEF = 64;

    localparam int DEV_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_PEEK   = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_QUEUE = 2'd1;
    localparam logic [1:0] ST_ALL_BUSY = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       released;
        logic       rd_en;
        logic       wr_en;
    } t_ctl;

endpackage

FILE: hdl/pdmq_fifo.sv
// ----------------------------------------------------------------------------
// pdmq_fifo
// Two-entry command queue between the classifier and the packet store.
// ----------------------------------------------------------------------------
module pdmq_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/pdmq_front.sv
// ----------------------------------------------------------------------------
// pdmq_front
// Request register, tag match, slot allocation and per-slot ring bookkeeping.
// Emits one packet-store command per request.
// ----------------------------------------------------------------------------
module pdmq_front #(
    parameter int NUM_QUEUES   = pdmq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = pdmq_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_WIDTH = pdmq_pkg::PACKET_WIDTH_DEF,
    parameter int AW           = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [1:0]                i_req_type,
    input  logic [pdmq_pkg::DEV_W-1:0] i_dev_id,
    input  logic [PACKET_WIDTH-1:0]   i_packet_data,
    output logic                      o_cmd_push,
    input  logic                      i_cmd_full,
    output pdmq_pkg::t_ctl            o_cmd_ctl,
    output logic [AW-1:0]             o_cmd_addr,
    output logic [PACKET_WIDTH-1:0]   o_cmd_data
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic                       r_vld;
    logic                       n_vld;
    logic [1:0]                 r_req;
    logic [pdmq_pkg::DEV_W-1:0] r_dev;
    logic [PACKET_WIDTH-1:0]    r_pkt;

    logic                       r_busy [NUM_QUEUES];
    logic [pdmq_pkg::DEV_W-1:0] r_tag  [NUM_QUEUES];
    logic [DW-1:0]              r_rptr [NUM_QUEUES];
    logic [FW-1:0]              r_fill [NUM_QUEUES];

    logic          load;
    logic          proc;
    logic          hit;
    logic [QW-1:0] hit_q;
    logic          any_free;
    logic [QW-1:0] free_q;
    logic [QW-1:0] sel_q;
    logic [DW:0]   wsum;
    logic [DW-1:0] widx;
    logic [DW-1:0] ridx;
    logic          do_ins;
    logic          do_pop;
    logic          last_pkt;
    pdmq_pkg::t_ctl ctl;

    assign o_full = r_vld && i_cmd_full;
    assign load   = i_push && !o_full;
    assign proc   = r_vld && !i_cmd_full;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (proc) begin
            n_vld = 1'b0;
        end
    end

    // Lowest index wins on both searches
    always_comb begin
        hit      = 1'b0;
        hit_q    = '0;
        any_free = 1'b0;
        free_q   = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
            if (r_busy[q] && (r_tag[q] == r_dev)) begin
                hit   = 1'b1;
                hit_q = QW'(q);
            end
            if (!r_busy[q]) begin
                any_free = 1'b1;
                free_q   = QW'(q);
            end
        end
    end

    always_comb begin
        ctl         = '0;
        ctl.status  = pdmq_pkg::ST_OK;
        sel_q       = hit ? hit_q : free_q;
        do_ins      = 1'b0;
        do_pop      = 1'b0;
        ridx        = r_rptr[sel_q];
        wsum        = (DW+1)'(r_rptr[sel_q]) + (DW+1)'(r_fill[sel_q]);
        widx        = (wsum >= (DW+1)'(QUEUE_DEPTH)) ?
                      DW'(wsum - (DW+1)'(QUEUE_DEPTH)) : DW'(wsum);
        last_pkt    = (r_fill[sel_q] == FW'(1));
        o_cmd_addr  = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH)) + AW'(ridx);
        case (r_req)
            pdmq_pkg::REQ_INSERT: begin
                o_cmd_addr = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH)) + AW'(widx);
                if (!hit && !any_free) begin
                    ctl.status = pdmq_pkg::ST_ALL_BUSY;
                end else if (r_fill[sel_q] == FW'(QUEUE_DEPTH)) begin
                    ctl.status = pdmq_pkg::ST_FULL;
                end else begin
                    ctl.wr_en = 1'b1;
                    do_ins    = 1'b1;
                end
            end
            pdmq_pkg::REQ_PEEK: begin
                if (!hit) begin
                    ctl.status = pdmq_pkg::ST_NO_QUEUE;
                end else begin
                    ctl.rd_en = 1'b1;
                end
            end
            pdmq_pkg::REQ_POP: begin
                if (!hit) begin
                    ctl.status = pdmq_pkg::ST_NO_QUEUE;
                end else begin
                    do_pop       = 1'b1;
                    ctl.released = last_pkt;
                end
            end
            default: begin
                ctl.status = pdmq_pkg::ST_OK;
            end
        endcase
    end

    assign o_cmd_push = proc;
    assign o_cmd_ctl  = ctl;
    assign o_cmd_data = r_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_busy[q] <= 1'b0;
                r_rptr[q] <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            r_vld <= n_vld;
            if (proc && do_ins) begin
                r_fill[sel_q] <= r_fill[sel_q] + FW'(1);
                r_busy[sel_q] <= 1'b1;
            end
            if (proc && do_pop) begin
                r_rptr[sel_q] <= (r_rptr[sel_q] == DW'(QUEUE_DEPTH - 1)) ?
                                 '0 : r_rptr[sel_q] + DW'(1);
                r_fill[sel_q] <= r_fill[sel_q] - FW'(1);
                if (last_pkt) begin
                    r_busy[sel_q] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= i_req_type;
            r_dev <= i_dev_id;
            r_pkt <= i_packet_data;
        end
        if (proc && do_ins) begin
            r_tag[sel_q] <= r_dev;
        end
    end

endmodule

FILE: hdl/pdmq_back.sv
// ----------------------------------------------------------------------------
// pdmq_back
// Packet store with registered read, then the result register that the
// output queue interface presents.
// ----------------------------------------------------------------------------
module pdmq_back #(
    parameter int NUM_QUEUES   = pdmq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = pdmq_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_WIDTH = pdmq_pkg::PACKET_WIDTH_DEF,
    parameter int AW           = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_empty,
    output logic                    o_cmd_pop,
    input  pdmq_pkg::t_ctl          i_cmd_ctl,
    input  logic [AW-1:0]           i_cmd_addr,
    input  logic [PACKET_WIDTH-1:0] i_cmd_data,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [1:0]              o_status,
    output logic [PACKET_WIDTH-1:0] o_packet_out,
    output logic                    o_slot_released
);

    localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;

    logic [PACKET_WIDTH-1:0] r_store [DEPTH];

    logic                    r_s1_vld;
    pdmq_pkg::t_ctl          r_s1_ctl;
    logic [PACKET_WIDTH-1:0] r_rdata;

    logic                    r_out_vld;
    logic [1:0]              r_out_status;
    logic [PACKET_WIDTH-1:0] r_out_pkt;
    logic                    r_out_rel;

    logic out_rdy;
    logic s1_rdy;
    logic adv;

    assign out_rdy   = !r_out_vld || i_pop;
    assign s1_rdy    = !r_s1_vld || out_rdy;
    assign o_cmd_pop = !i_cmd_empty && s1_rdy;
    assign adv       = r_s1_vld && out_rdy;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd_ctl.wr_en) begin
            r_store[i_cmd_addr] <= i_cmd_data;
        end
        if (o_cmd_pop) begin
            r_rdata <= r_store[i_cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_ctl <= i_cmd_ctl;
        end
        if (adv) begin
            r_out_status <= r_s1_ctl.status;
            r_out_rel    <= r_s1_ctl.released;
            // zero the data beat on anything but a successful peek
            r_out_pkt    <= r_s1_ctl.rd_en ? r_rdata : '0;
        end
    end

    assign o_empty         = !r_out_vld;
    assign o_status        = r_out_status;
    assign o_packet_out    = r_out_pkt;
    assign o_slot_released = r_out_rel;

endmodule

FILE: hdl/per_device_message_queues_unit.sv
// ----------------------------------------------------------------------------
// per_device_message_queues_unit
// Pool of per-device packet FIFOs with tag-matched slot allocation.
// ----------------------------------------------------------------------------
// Requests (insert, peek, pop) enter through a queue-style port and each
// produces exactly one result beat, in request order. The front stage matches
// the device id against all busy slot tags, allocates the lowest free slot on
// a new device and updates the per-slot ring pointers; a two-entry command
// queue then feeds the packet memory, whose registered read is followed by
// the result register. One request is taken per clock when the result side
// keeps up; a result passes the request register, the command queue, the
// memory read and the result register, in that order. The packet memory
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module per_device_message_queues_unit #(
    parameter int NUM_QUEUES   = pdmq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = pdmq_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_WIDTH = pdmq_pkg::PACKET_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_req_type,
    input  logic [pdmq_pkg::DEV_W-1:0] i_dev_id,
    input  logic [PACKET_WIDTH-1:0]    i_packet_data,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 o_status,
    output logic [PACKET_WIDTH-1:0]    o_packet_out,
    output logic                       o_slot_released
);

    localparam int AW   = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int CTLW = $bits(pdmq_pkg::t_ctl);
    localparam int CW   = CTLW + AW + PACKET_WIDTH;

    logic                    f_push;
    logic                    f_full;
    pdmq_pkg::t_ctl          f_ctl;
    logic [AW-1:0]           f_addr;
    logic [PACKET_WIDTH-1:0] f_data;

    logic                    b_pop;
    logic                    b_empty;
    logic [CW-1:0]           b_word;
    pdmq_pkg::t_ctl          b_ctl;
    logic [AW-1:0]           b_addr;
    logic [PACKET_WIDTH-1:0] b_data;

    pdmq_front #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PACKET_WIDTH (PACKET_WIDTH),
        .AW           (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_dev_id      (i_dev_id),
        .i_packet_data (i_packet_data),
        .o_cmd_push    (f_push),
        .i_cmd_full    (f_full),
        .o_cmd_ctl     (f_ctl),
        .o_cmd_addr    (f_addr),
        .o_cmd_data    (f_data)
    );

    pdmq_fifo #(
        .W (CW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_addr, f_data}),
        .o_full  (f_full),
        .i_pop   (b_pop),
        .o_empty (b_empty),
        .o_data  (b_word)
    );

    assign b_ctl  = b_word[CW-1 -: CTLW];
    assign b_addr = b_word[PACKET_WIDTH +: AW];
    assign b_data = b_word[PACKET_WIDTH-1:0];

    pdmq_back #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PACKET_WIDTH (PACKET_WIDTH),
        .AW           (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_empty     (b_empty),
        .o_cmd_pop       (b_pop),
        .i_cmd_ctl       (b_ctl),
        .i_cmd_addr      (b_addr),
        .i_cmd_data      (b_data),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_status        (o_status),
        .o_packet_out    (o_packet_out),
        .o_slot_released (o_slot_released)
    );

endmodule
